// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the soft clip locator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high
`define CSCL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that stays live through reset
`define CSCL_ASSERT_RST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/cscl_pkg.sv =====
// ----------------------------------------------------------------------------
// cscl_pkg
// Types and constants shared by the CIGAR soft clip locator modules.
// ----------------------------------------------------------------------------
package cscl_pkg;

   localparam int OpCodeWidth = 4;
   localparam int LenWidth    = 28;
   localparam int PosWidth    = 32;

   // Queue between the decode front and the execute back
   localparam int QueueDepth  = 4;
   localparam int QueuePtrW   = $clog2(QueueDepth);
   localparam int QueueCntW   = $clog2(QueueDepth + 1);

   // CIGAR operation codes
   localparam logic [OpCodeWidth-1:0] OpM  = 4'd0;
   localparam logic [OpCodeWidth-1:0] OpI  = 4'd1;
   localparam logic [OpCodeWidth-1:0] OpD  = 4'd2;
   localparam logic [OpCodeWidth-1:0] OpN  = 4'd3;
   localparam logic [OpCodeWidth-1:0] OpS  = 4'd4;
   localparam logic [OpCodeWidth-1:0] OpEq = 4'd7;
   localparam logic [OpCodeWidth-1:0] OpX  = 4'd8;

   // Operation class, as seen by the execute stage
   typedef enum logic [1:0] {
      CLS_NONE    = 2'd0,
      CLS_ADVANCE = 2'd1,
      CLS_INSERT  = 2'd2,
      CLS_CLIP    = 2'd3
   } op_class_type;

   // One classified word waiting for execution
   typedef struct packed {
      op_class_type          op_class;
      logic [LenWidth-1:0]   length;
      logic                  first;
      logic [PosWidth-1:0]   start;
      logic                  last;
   } op_entry_type;

   // Queue status seen by the front and the back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== hw/rtl/cigar_soft_clip_locator_top.sv =====
// ----------------------------------------------------------------------------
// cigar_soft_clip_locator_top
// Walks CIGAR operations and reports soft clips with read/genome positions.
//
//   channel | direction | handshake            | word
//   req     | in        | req_valid/req_stall  | one CIGAR operation
//   rsp     | out       | rsp_valid/rsp_stall  | one result per operation
//   csr     | in        | csr_valid/csr_ready  | padded_mode
//
// One operation per cycle sustained while rsp_stall is low. An accepted
// operation is written to the queue; the position add then loads the output
// register and rsp_valid. The position update (one 32-bit add per position)
// sets the cycle time. Reset clears the positions, clip flag, padded_mode
// and the queue. req_stall rises only when the four-entry queue is full;
// rsp_stall holds the output word and lets the queue fill behind it.
// ----------------------------------------------------------------------------
module cigar_soft_clip_locator_top import cscl_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [OpCodeWidth-1:0]  req_op_code,
   input  logic [LenWidth-1:0]     req_op_length,
   input  logic                    req_first_op,
   input  logic [PosWidth-1:0]     req_start_position,
   input  logic                    req_last_op,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_clip_valid,
   output logic [LenWidth-1:0]     rsp_clip_size,
   output logic [PosWidth-1:0]     rsp_clip_read_pos,
   output logic [PosWidth-1:0]     rsp_clip_genome_pos,
   output logic                    rsp_alignment_done,
   output logic                    rsp_any_clip_found,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic                    csr_padded_mode
);

   logic              padded_ff;
   logic              push, pop;
   op_entry_type      push_entry, head_entry;
   queue_status_type  q_status;

   // Configuration register, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         padded_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         padded_ff <= csr_padded_mode;
      end
   end

   cscl_front u_front (
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op_code        (req_op_code),
      .req_op_length      (req_op_length),
      .req_first_op       (req_first_op),
      .req_start_position (req_start_position),
      .req_last_op        (req_last_op),
      .q_status           (q_status),
      .push               (push),
      .push_entry         (push_entry)
   );

   cscl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   cscl_back u_back (
      .clock               (clock),
      .reset               (reset),
      .padded_mode         (padded_ff),
      .q_status            (q_status),
      .head_entry          (head_entry),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_clip_valid      (rsp_clip_valid),
      .rsp_clip_size       (rsp_clip_size),
      .rsp_clip_read_pos   (rsp_clip_read_pos),
      .rsp_clip_genome_pos (rsp_clip_genome_pos),
      .rsp_alignment_done  (rsp_alignment_done),
      .rsp_any_clip_found  (rsp_any_clip_found)
   );

endmodule

// ===== hw/rtl/cscl_front.sv =====
// ----------------------------------------------------------------------------
// cscl_front
// Accepts request words and classifies the CIGAR operation code.
// ----------------------------------------------------------------------------
module cscl_front import cscl_pkg::*; (
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [OpCodeWidth-1:0]  req_op_code,
   input  logic [LenWidth-1:0]     req_op_length,
   input  logic                    req_first_op,
   input  logic [PosWidth-1:0]     req_start_position,
   input  logic                    req_last_op,
   input  queue_status_type        q_status,
   output logic                    push,
   output op_entry_type            push_entry
);

   op_class_type op_class;

   // Map the op code onto its execution class
   always_comb begin
      case (req_op_code) inside
         OpM, OpD, OpN, OpEq, OpX: op_class = CLS_ADVANCE;
         OpI:                      op_class = CLS_INSERT;
         OpS:                      op_class = CLS_CLIP;
         default:                  op_class = CLS_NONE;
      endcase
   end

   // Stall only on a full queue
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   // Pack the classified word
   always_comb begin
      push_entry.op_class = op_class;
      push_entry.length   = req_op_length;
      push_entry.first    = req_first_op;
      push_entry.start    = req_start_position;
      push_entry.last     = req_last_op;
   end

endmodule

// ===== hw/rtl/cscl_queue.sv =====
// ----------------------------------------------------------------------------
// cscl_queue
// Short FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
module cscl_queue import cscl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  op_entry_type      push_entry,
   input  logic              pop,
   output op_entry_type      head_entry,
   output queue_status_type  q_status
);

   op_entry_type            slot_ff [QueueDepth];
   logic [QueuePtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]    count_ff,  count_in;

   // Advance pointers and the fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QueuePtrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QueuePtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QueueCntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QueueCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry     = slot_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == QueueCntW'(QueueDepth));
   assign q_status.empty = (count_ff == '0);

endmodule

// ===== hw/rtl/cscl_back.sv =====
// ----------------------------------------------------------------------------
// cscl_back
// Executes classified words: walks the positions and registers the result.
// ----------------------------------------------------------------------------
module cscl_back import cscl_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   padded_mode,
   input  queue_status_type       q_status,
   input  op_entry_type           head_entry,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_clip_valid,
   output logic [LenWidth-1:0]    rsp_clip_size,
   output logic [PosWidth-1:0]    rsp_clip_read_pos,
   output logic [PosWidth-1:0]    rsp_clip_genome_pos,
   output logic                   rsp_alignment_done,
   output logic                   rsp_any_clip_found
);

   logic [PosWidth-1:0] genome_ff, genome_in;
   logic [PosWidth-1:0] read_ff,   read_in;
   logic                seen_ff,   seen_in;

   logic                out_valid_ff, out_valid_in;
   logic                clip_valid_ff, clip_valid_in;
   logic [LenWidth-1:0] clip_size_ff, clip_size_in;
   logic [PosWidth-1:0] clip_read_ff, clip_read_in;
   logic [PosWidth-1:0] clip_gen_ff,  clip_gen_in;
   logic                done_ff,      done_in;
   logic                found_ff,     found_in;

   logic [PosWidth-1:0] g_base, r_base, len_ext, g_sum, r_sum;
   logic                s_base;

   // Take the head when the output register is free or being drained
   assign pop = !q_status.empty && (!out_valid_ff || !rsp_stall);

   // Reload on the first operation of an alignment
   always_comb begin
      g_base  = head_entry.first ? head_entry.start : genome_ff;
      r_base  = head_entry.first ? '0 : read_ff;
      s_base  = head_entry.first ? 1'b0 : seen_ff;
      len_ext = PosWidth'(head_entry.length);
      g_sum   = g_base + len_ext;
      r_sum   = r_base + len_ext;
   end

   // Apply the operation
   always_comb begin
      genome_in     = g_base;
      read_in       = r_base;
      seen_in       = s_base;
      clip_valid_in = 1'b0;
      clip_size_in  = '0;
      clip_read_in  = '0;
      clip_gen_in   = '0;
      case (head_entry.op_class)
         CLS_ADVANCE: begin
            genome_in = g_sum;
            read_in   = r_sum;
         end
         CLS_INSERT: begin
            read_in = r_sum;
            if (padded_mode) begin
               genome_in = g_sum;
            end
         end
         CLS_CLIP: begin
            // A leading clip moves the read position past itself first
            if (head_entry.first) begin
               read_in = r_sum;
            end
            seen_in       = 1'b1;
            clip_valid_in = 1'b1;
            clip_size_in  = head_entry.length;
            clip_read_in  = read_in;
            clip_gen_in   = g_base;
         end
         default: begin
         end
      endcase
      done_in  = head_entry.last;
      found_in = seen_in;
   end

   // Output register valid: load on pop, drop when taken
   always_comb begin
      out_valid_in = out_valid_ff;
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         genome_ff    <= '0;
         read_ff      <= '0;
         seen_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            genome_ff <= genome_in;
            read_ff   <= read_in;
            seen_ff   <= seen_in;
         end
      end
   end

   // Hold the result word until it is taken
   always_ff @(posedge clock) begin
      if (pop) begin
         clip_valid_ff <= clip_valid_in;
         clip_size_ff  <= clip_size_in;
         clip_read_ff  <= clip_read_in;
         clip_gen_ff   <= clip_gen_in;
         done_ff       <= done_in;
         found_ff      <= found_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_clip_valid      = clip_valid_ff;
   assign rsp_clip_size       = clip_size_ff;
   assign rsp_clip_read_pos   = clip_read_ff;
   assign rsp_clip_genome_pos = clip_gen_ff;
   assign rsp_alignment_done  = done_ff;
   assign rsp_any_clip_found  = found_ff;

endmodule

// ===== hw/rtl/cscl_checker.sv =====
// ----------------------------------------------------------------------------
// cscl_checker
// Port-level checks on the soft clip locator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cscl_checker import cscl_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic                    rsp_clip_valid,
   input  logic [LenWidth-1:0]     rsp_clip_size,
   input  logic [PosWidth-1:0]     rsp_clip_read_pos,
   input  logic [PosWidth-1:0]     rsp_clip_genome_pos,
   input  logic                    rsp_alignment_done,
   input  logic                    rsp_any_clip_found
);

   // Whole result word, for the hold check
   logic [LenWidth+2*PosWidth+2:0] rsp_word;

   assign rsp_word = {rsp_clip_valid, rsp_clip_size, rsp_clip_read_pos,
                      rsp_clip_genome_pos, rsp_alignment_done, rsp_any_clip_found};

   // Output word is empty in the cycle after a reset cycle
   `CSCL_ASSERT_RST(a_rsp_idle_after_reset, clock, reset |=> !rsp_valid, "rsp_valid after reset")

   // A stalled result word holds
   `CSCL_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word),
      "stalled rsp changed")

   // A reported clip always sets the alignment clip flag
   `CSCL_ASSERT(a_clip_sets_found, clock, reset,
      rsp_valid && rsp_clip_valid |-> rsp_any_clip_found,
      "clip without found flag")

   // Non-clip results carry zero clip fields
   `CSCL_ASSERT(a_noclip_zero, clock, reset,
      rsp_valid && !rsp_clip_valid |-> rsp_clip_size == '0
         && rsp_clip_read_pos == '0 && rsp_clip_genome_pos == '0,
      "non-clip fields not zero")

endmodule

bind cigar_soft_clip_locator_top cscl_checker u_cscl_checker (.*);
